FILE: rtl/sorted_deadline_timer_queue_unit_defines.svh
// assertion macros shared by the checker
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SDTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sdtq_pkg.sv
package sdtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int TIME_W      = 48;
    localparam int PERIOD_W    = 32;
    localparam int HANDLE_W    = 4;
    localparam int KIND_W      = 2;

    localparam int S_TDATA_W   = 128;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 3;

    localparam logic [TIME_W-1:0] MIN_ARM_US = TIME_W'(100);

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_EXPIRED  = 2'd1,
        KIND_REARM    = 2'd2,
        KIND_ADD_FULL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_POP_INSERT,
        CELL_CLR_FRESH
    } cell_op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                fresh;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    function automatic logic [TIME_W-1:0] delay_to(input logic [TIME_W-1:0] when_us,
                                                   input logic [TIME_W-1:0] now_us);
        logic [TIME_W:0] diff;
        diff = {1'b0, when_us} - {1'b0, now_us};
        if (diff[TIME_W] || (diff[TIME_W-1:0] < MIN_ARM_US)) begin
            return MIN_ARM_US;
        end
        return diff[TIME_W-1:0];
    endfunction

endpackage

FILE: rtl/sdtq_cell.sv
module sdtq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  sdtq_pkg::cell_ctrl_t ctrl,
    input  sdtq_pkg::entry_t   prev_entry,
    input  logic               prev_ge,
    input  sdtq_pkg::entry_t   next_entry,
    input  logic               next_ge,
    output sdtq_pkg::entry_t   entry,
    output logic               ge
);
    import sdtq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays ahead of the key (ties keep older first)
    assign ge    = entry_reg.valid && (entry_reg.deadline <= ctrl.new_entry.deadline);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                entry_next = entry_reg;
            end
            CELL_INSERT: begin
                if (ge) begin
                    entry_next = entry_reg;
                end else if (prev_ge) begin
                    entry_next = ctrl.new_entry;
                end else begin
                    entry_next = prev_entry;
                end
            end
            CELL_POP: begin
                entry_next = next_entry;
            end
            CELL_POP_INSERT: begin
                if (next_ge) begin
                    entry_next = next_entry;
                end else if (ge) begin
                    entry_next = ctrl.new_entry;
                end else begin
                    entry_next = entry_reg;
                end
            end
            CELL_CLR_FRESH: begin
                entry_next.fresh = 1'b0;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            entry_reg.fresh <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: rtl/sorted_deadline_timer_queue_unit.sv
// Timer queue kept sorted by deadline in a row of cells, one timer per cell, ties in
// insertion order. An add returns one item with the slot handle and, when the timer
// became the earliest, the re-arm delay (at least 100 us). A tick first clears the fresh
// marks, then, while the output register is free, pops each expired timer from the head
// of the row, putting a periodic one back in the same cycle, and ends with a re-arm item
// for the new head unless the queue ends empty.
// The row moves one entry per cycle while the output register is not stalled, and
// results leave through a single output register.
// A new item is taken only while no tick is running and the output register is free.
module sorted_deadline_timer_queue_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // time_now[47:0], deadline[95:48], period[127:96]
    input  logic [sdtq_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [sdtq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // handle[3:0], earliest_changed[4], arm_delay[52:5], zero fill[55:53]
    output logic [sdtq_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[1:0], arm_valid[2]
    output logic [sdtq_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import sdtq_pkg::*;

    state_t                  state_reg, state_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [QUEUE_DEPTH-1:0]  used_reg, used_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    cell_ctrl_t              ctrl;
    entry_t                  cell_q [QUEUE_DEPTH];
    logic                    ge_w   [QUEUE_DEPTH];
    entry_t                  prev_e [QUEUE_DEPTH];
    logic                    prev_g [QUEUE_DEPTH];
    entry_t                  next_e [QUEUE_DEPTH];
    logic                    next_g [QUEUE_DEPTH];

    logic [TIME_W-1:0]       in_now;
    logic [TIME_W-1:0]       in_deadline;
    logic [PERIOD_W-1:0]     in_period;
    logic                    out_free;
    logic [SLOT_W-1:0]       free_slot;
    logic                    free_found;
    logic                    head_exp;
    logic                    next_exp;
    logic                    reinsert;
    logic [TIME_W:0]         reins_sum;
    logic [TIME_W-1:0]       reins_key;
    logic                    first;
    logic                    tick_last;

    assign in_now      = s_tdata[TIME_W-1:0];
    assign in_deadline = s_tdata[2*TIME_W-1:TIME_W];
    assign in_period   = s_tdata[2*TIME_W+PERIOD_W-1:2*TIME_W];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // cell chain
    always_comb begin
        prev_e[0] = '0;
        prev_g[0] = 1'b1;
        next_e[QUEUE_DEPTH-1] = '0;
        next_g[QUEUE_DEPTH-1] = 1'b0;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            prev_e[i]   = cell_q[i-1];
            prev_g[i]   = ge_w[i-1];
            next_e[i-1] = cell_q[i];
            next_g[i-1] = ge_w[i];
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sdtq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_entry (prev_e[g]),
            .prev_ge    (prev_g[g]),
            .next_entry (next_e[g]),
            .next_ge    (next_g[g]),
            .entry      (cell_q[g]),
            .ge         (ge_w[g])
        );
    end

    // lowest free slot
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign head_exp  = cell_q[0].valid && !cell_q[0].fresh && (cell_q[0].deadline <= now_reg);
    assign next_exp  = cell_q[1].valid && !cell_q[1].fresh && (cell_q[1].deadline <= now_reg);
    assign reinsert  = (cell_q[0].period != '0);
    assign reins_sum = {1'b0, now_reg} + (TIME_W+1)'(cell_q[0].period);
    assign reins_key = reins_sum[TIME_W] ? {TIME_W{1'b1}} : reins_sum[TIME_W-1:0];
    assign first     = !ge_w[0];
    assign tick_last = !next_exp && !(cell_q[1].valid || reinsert);

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        used_next     = used_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl.op                 = CELL_HOLD;
        ctrl.new_entry.valid    = 1'b1;
        ctrl.new_entry.fresh    = 1'b0;
        ctrl.new_entry.slot     = free_slot;
        ctrl.new_entry.deadline = in_deadline;
        ctrl.new_entry.period   = in_period;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (op_t'(s_tuser[0]) == OP_ADD) begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b1;
                        if (!free_found) begin
                            m_tdata_next = '0;
                            m_tuser_next = {1'b0, KIND_ADD_FULL};
                        end else begin
                            ctrl.op              = CELL_INSERT;
                            used_next[free_slot] = 1'b1;
                            m_tdata_next = {3'b000,
                                            first ? delay_to(in_deadline, in_now)
                                                  : {TIME_W{1'b0}},
                                            first, HANDLE_W'(free_slot)};
                            m_tuser_next = {first, KIND_ADD_OK};
                        end
                    end else begin
                        now_next   = in_now;
                        ctrl.op    = CELL_CLR_FRESH;
                        state_next = ST_TICK;
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    if (head_exp) begin
                        ctrl.op                 = reinsert ? CELL_POP_INSERT : CELL_POP;
                        ctrl.new_entry.fresh    = 1'b1;
                        ctrl.new_entry.slot     = cell_q[0].slot;
                        ctrl.new_entry.deadline = reins_key;
                        ctrl.new_entry.period   = cell_q[0].period;
                        if (!reinsert) begin
                            used_next[cell_q[0].slot] = 1'b0;
                        end
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = tick_last;
                        m_tdata_next  = {3'b000, {TIME_W{1'b0}}, 1'b0,
                                         HANDLE_W'(cell_q[0].slot)};
                        m_tuser_next  = {1'b0, KIND_EXPIRED};
                        if (tick_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        if (cell_q[0].valid) begin
                            m_tvalid_next = 1'b1;
                            m_tlast_next  = 1'b1;
                            m_tdata_next  = {3'b000, delay_to(cell_q[0].deadline, now_reg),
                                             1'b0, {HANDLE_W{1'b0}}};
                            m_tuser_next  = {1'b1, KIND_REARM};
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

FILE: rtl/sdtq_checker.sv
`include "sorted_deadline_timer_queue_unit_defines.svh"

module sdtq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sdtq_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sdtq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sdtq_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import sdtq_pkg::*;

    // stalled item holds
    `SDTQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled item changed")

    // an add answers in the next cycle with a single closing item
    `SDTQ_ASSERT_NEXT(a_add_resp, s_tvalid && s_tready && (s_tuser[0] == OP_ADD), m_tvalid && m_tlast && (m_tuser[1:0] == KIND_ADD_OK || m_tuser[1:0] == KIND_ADD_FULL), "add not answered")

    // arm flag only on re-arm or a new earliest add
    `SDTQ_ASSERT_NOW(a_arm_kind, m_tvalid, m_tuser[2] == ((m_tuser[1:0] == KIND_REARM) || ((m_tuser[1:0] == KIND_ADD_OK) && m_tdata[4])), "arm flag mismatch")

    // armed delay never below the floor
    `SDTQ_ASSERT_NOW(a_arm_min, m_tvalid && m_tuser[2], m_tdata[HANDLE_W+1+TIME_W-1:HANDLE_W+1] >= MIN_ARM_US, "arm delay below minimum")

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sdtq_pkg::*;

    localparam logic [TIME_W-1:0]   TIME_MAX    = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;
    localparam int                  RANDOM_REQS = 230;
    localparam int                  CYCLE_LIMIT = 600000;

    typedef struct {
        op_t                 op;
        logic [TIME_W-1:0]   now_us;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } timer_req_t;

    typedef struct {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic                earliest_changed;
        logic [TIME_W-1:0]   arm_delay;
        logic                arm_valid;
        logic                last;
    } timer_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    timer_req_t    timer_reqs[$];
    timer_result_t timer_results_due[$];
    timer_req_t    cur_req;
    timer_result_t want;
    int            total_items = 1;
    int            accepted_items = 0;
    int            errors = 0;
    int            cycles = 0;

    // shadow copy of the timer queue
    logic [TIME_W-1:0]   shadow_deadline[QUEUE_DEPTH];
    logic [PERIOD_W-1:0] shadow_period[QUEUE_DEPTH];
    bit                  shadow_used[QUEUE_DEPTH];
    logic [SLOT_W-1:0]   shadow_order[QUEUE_DEPTH];
    int                  shadow_count = 0;

    sorted_deadline_timer_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand48();
        logic [31:0] hi;
        hi = $urandom();
        return {hi[15:0], 32'($urandom())};
    endfunction

    function automatic logic [TIME_W-1:0] wait_us(input logic [TIME_W-1:0] when_us,
                                                  input logic [TIME_W-1:0] now_us);
        logic [TIME_W-1:0] gap;
        if (when_us <= now_us) begin
            return MIN_ARM_US;
        end
        gap = when_us - now_us;
        return (gap < MIN_ARM_US) ? MIN_ARM_US : gap;
    endfunction

    function automatic int idle_phase();
        if (accepted_items * 3 < total_items) begin
            return 0;
        end else if (accepted_items * 3 < 2 * total_items) begin
            return 1;
        end
        return 2;
    endfunction

    task automatic queue_req(input op_t op, input logic [TIME_W-1:0] now_us,
                             input logic [TIME_W-1:0] deadline,
                             input logic [PERIOD_W-1:0] period);
        timer_reqs.push_back('{op: op, now_us: now_us, deadline: deadline, period: period});
    endtask

    task automatic note_result(input kind_t kind, input logic [HANDLE_W-1:0] handle,
                               input logic changed, input logic [TIME_W-1:0] delay,
                               input logic arm_valid, input logic last);
        timer_results_due.push_back('{kind: kind, handle: handle, earliest_changed: changed,
                                      arm_delay: delay, arm_valid: arm_valid, last: last});
    endtask

    // ties go behind every timer with the same deadline
    task automatic place_timer(input logic [SLOT_W-1:0] slot, output bit at_head);
        int pos;
        int i;
        pos = 0;
        while (pos < shadow_count
               && shadow_deadline[shadow_order[pos]] <= shadow_deadline[slot]) begin
            pos++;
        end
        for (i = shadow_count; i > pos; i--) begin
            shadow_order[i] = shadow_order[i-1];
        end
        shadow_order[pos] = slot;
        shadow_count++;
        at_head = (pos == 0);
    endtask

    task automatic compute_timer_results(input timer_req_t req);
        logic [SLOT_W-1:0] gone[QUEUE_DEPTH];
        logic [TIME_W:0]   next_dl;
        int                n;
        int                i;
        int                slot;
        bit                at_head;
        if (req.op == OP_ADD) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                note_result(KIND_ADD_FULL, '0, 1'b0, '0, 1'b0, 1'b1);
            end else begin
                slot = 0;
                while (shadow_used[slot]) begin
                    slot++;
                end
                shadow_used[slot] = 1'b1;
                shadow_deadline[slot] = req.deadline;
                shadow_period[slot] = req.period;
                place_timer(SLOT_W'(slot), at_head);
                note_result(KIND_ADD_OK, HANDLE_W'(slot), at_head,
                            at_head ? wait_us(req.deadline, req.now_us) : '0, at_head, 1'b1);
            end
        end else begin
            n = 0;
            while (n < shadow_count && shadow_deadline[shadow_order[n]] <= req.now_us) begin
                gone[n] = shadow_order[n];
                n++;
            end
            for (i = n; i < shadow_count; i++) begin
                shadow_order[i-n] = shadow_order[i];
            end
            shadow_count -= n;
            // periodic timers go back in expiry order
            for (i = 0; i < n; i++) begin
                if (shadow_period[gone[i]] != '0) begin
                    next_dl = {1'b0, req.now_us} + (TIME_W+1)'(shadow_period[gone[i]]);
                    shadow_deadline[gone[i]] = next_dl[TIME_W] ? TIME_MAX : next_dl[TIME_W-1:0];
                    place_timer(gone[i], at_head);
                end else begin
                    shadow_used[gone[i]] = 1'b0;
                end
            end
            for (i = 0; i < n; i++) begin
                note_result(KIND_EXPIRED, HANDLE_W'(gone[i]), 1'b0, '0, 1'b0,
                            (i == n - 1) && (shadow_count == 0));
            end
            if (shadow_count > 0) begin
                note_result(KIND_REARM, '0, 1'b0,
                            wait_us(shadow_deadline[shadow_order[0]], req.now_us), 1'b1, 1'b1);
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                compute_timer_results(cur_req);
                accepted_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (timer_reqs.size() > 0
                    && $urandom_range(0, 99) >= (idle_phase() == 0 ? 23 :
                                                 idle_phase() == 1 ? 84 : 0)) begin
                    cur_req = timer_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.period, cur_req.deadline, cur_req.now_us};
                    s_tuser <= cur_req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= (idle_phase() == 0 ? 84 :
                                                  idle_phase() == 1 ? 23 : 0);
            if (m_tvalid && m_tready) begin
                if (timer_results_due.size() == 0) begin
                    $error("unexpected result item: kind %0d handle %0d",
                           m_tuser[1:0], m_tdata[3:0]);
                    errors++;
                end else begin
                    want = timer_results_due.pop_front();
                    if (m_tuser[1:0] !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
                        errors++;
                    end
                    if (m_tdata[3:0] !== want.handle) begin
                        $error("handle: expected %0d, got %0d", want.handle, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[4] !== want.earliest_changed) begin
                        $error("earliest_changed: expected %0d, got %0d",
                               want.earliest_changed, m_tdata[4]);
                        errors++;
                    end
                    if (m_tdata[52:5] !== want.arm_delay) begin
                        $error("arm_delay: expected %0d, got %0d", want.arm_delay,
                               m_tdata[52:5]);
                        errors++;
                    end
                    if (m_tuser[2] !== want.arm_valid) begin
                        $error("arm_valid: expected %0d, got %0d", want.arm_valid, m_tuser[2]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0]   clock_us;
        logic [TIME_W-1:0]   dl;
        logic [TIME_W-1:0]   last_dl;
        logic [TIME_W-1:0]   now_us;
        logic [PERIOD_W-1:0] per;
        int                  periodic_budget;
        int                  random_items;
        int                  n_add;
        int                  n_tick;
        int                  i;

        // empty queue, ties, extremes, overdue deadlines
        queue_req(OP_TICK, '0, '0, '0);
        queue_req(OP_ADD, '0, '0, '0);
        queue_req(OP_ADD, '0, '0, 32'd5);
        queue_req(OP_ADD, 48'd10, TIME_MAX, PERIOD_MAX);
        queue_req(OP_ADD, TIME_MAX, 48'd50, '0);
        queue_req(OP_TICK, '0, TIME_MAX, PERIOD_MAX);
        queue_req(OP_TICK, 48'd100, '0, '0);
        queue_req(OP_ADD, '0, 48'd1000000, '0);
        // fill up with new earliest timers, then one add too many
        for (i = 0; i < 13; i++) begin
            queue_req(OP_ADD, '0, 48'd104 - 48'(i), '0);
        end
        queue_req(OP_ADD, 48'd7, 48'd3, 32'd9);
        // expire everything, periodic ones saturate
        queue_req(OP_TICK, TIME_MAX, '0, '0);
        periodic_budget = 6;

        clock_us = (rand48() >> 3) | 48'h100000;
        last_dl = clock_us;
        random_items = 0;
        while (random_items < RANDOM_REQS) begin
            n_add = $urandom_range(1, 18);
            for (i = 0; i < n_add; i++) begin
                clock_us += 48'($urandom_range(0, 40));
                per = '0;
                if (periodic_budget > 0 && $urandom_range(0, 9) == 0) begin
                    periodic_budget--;
                    per = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 3000);
                end
                if ($urandom_range(0, 5) == 0) begin
                    dl = last_dl;
                end else begin
                    dl = clock_us + 48'($urandom_range(0, 4000)) - 48'd500;
                end
                last_dl = dl;
                now_us = ($urandom_range(0, 11) == 0) ? rand48() : clock_us;
                queue_req(OP_ADD, now_us, dl, per);
                random_items++;
            end
            n_tick = $urandom_range(1, 3);
            for (i = 0; i < n_tick; i++) begin
                clock_us += 48'($urandom_range(0, 2500));
                now_us = ($urandom_range(0, 11) == 0) ? rand48() : clock_us;
                queue_req(OP_TICK, now_us, rand48(), $urandom());
                random_items++;
            end
        end
        total_items = timer_reqs.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items < total_items || timer_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (QUEUE_DEPTH + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
